// ===== src/bqc_pkg.sv =====
// Package for the biquad cascade: sizes, codes, coefficient ramp and fixed-point helpers.
// No dependencies.
package bqc_pkg;

    localparam int MaxSections   = 16;
    localparam int MaxChannels   = 2;
    localparam int CoeffsPerSect = 5;
    localparam int SecW          = 4;
    localparam int CntW          = 5;
    localparam int ChW           = 1;
    localparam int CidxW         = 3;
    localparam int PosW          = 10;
    localparam int CfgIdxW       = 2;
    localparam int CfgDataW      = 5;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_SMOOTH   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SECTIONS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CHANNELS = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_BLKLOG2  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH,
        ST_OUT
    } t_state;

    // Per-cell coefficient context for one sample.
    typedef struct packed {
        logic             ramping;
        logic             smooth;
        logic [3:0]       log2;
        logic [PosW-1:0]  pos;
    } t_coef_ctx;

    typedef struct packed {
        logic               wr_en;
        logic [SecW-1:0]    sec;
        logic [CidxW-1:0]   cidx;
        logic [31:0]        value;
        logic               commit;
        logic               settle;
    } t_bank_ctl;

    // Effective coefficient: while ramping, old + floor((cur-old)*pos / 2^L); else old when smoothing, else cur.
    function automatic logic signed [31:0] coef_eff(
        input logic signed [31:0] cur,
        input logic signed [31:0] old,
        input t_coef_ctx          ctx
    );
        logic signed [32:0] d;
        logic signed [43:0] p;
        logic signed [43:0] sh;
        begin
            d  = 33'(cur) - 33'(old);
            p  = 44'(d) * $signed({1'b0, ctx.pos});
            sh = p >>> ctx.log2;
            if (ctx.ramping) coef_eff = 32'(44'(old) + sh);
            else if (ctx.smooth) coef_eff = old;
            else coef_eff = cur;
        end
    endfunction

endpackage

// ===== src/bqc_if.sv =====
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
interface bqc_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bqc_cell.sv =====
// One biquad cell: holds coefficient banks and history for one section.
// A single multiplier walks the five products of the section; uses bqc_pkg.
module bqc_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bqc_pkg::t_bank_ctl     i_bank,
    input  logic [bqc_pkg::SecW-1:0] i_my_sec,
    input  logic                   i_start,
    input  logic signed [31:0]     i_x,
    input  logic [bqc_pkg::ChW-1:0] i_ch,
    input  bqc_pkg::t_coef_ctx     i_ctx,
    output logic                   o_done,
    output logic signed [31:0]     o_y
);
    logic signed [31:0] r_cur [bqc_pkg::CoeffsPerSect];
    logic signed [31:0] r_old [bqc_pkg::CoeffsPerSect];
    logic signed [31:0] r_pend [bqc_pkg::CoeffsPerSect];
    logic signed [31:0] r_x1 [bqc_pkg::MaxChannels];
    logic signed [31:0] r_x2 [bqc_pkg::MaxChannels];
    logic signed [31:0] r_y1 [bqc_pkg::MaxChannels];
    logic signed [31:0] r_y2 [bqc_pkg::MaxChannels];
    logic [2:0]          r_step;
    logic                r_busy;
    logic signed [39:0]  r_acc;
    logic signed [31:0]  r_x;
    logic [bqc_pkg::ChW-1:0] r_ch;
    logic signed [31:0]  r_coef;
    logic signed [31:0]  r_sig;
    logic                r_mvalid;
    logic                r_neg;
    logic                r_last;
    logic signed [63:0]  r_prod;
    logic                r_pvalid;
    logic                r_pneg;
    logic                r_plast;
    logic                r_done;
    logic signed [31:0]  r_y;

    logic signed [31:0]  n_coef;
    logic signed [31:0]  n_sig;
    logic signed [39:0]  term;
    logic signed [39:0]  sum;
    logic signed [31:0]  sat;

    always_comb begin
        n_coef = bqc_pkg::coef_eff(r_cur[r_step], r_old[r_step], i_ctx);
        case (r_step)
            3'd0:    n_sig = r_x;
            3'd1:    n_sig = r_x1[r_ch];
            3'd2:    n_sig = r_x2[r_ch];
            3'd3:    n_sig = r_y1[r_ch];
            3'd4:    n_sig = r_y2[r_ch];
            default: n_sig = '0;
        endcase
        // five terms of up to 2^35 each: the exact sum needs 39 bits
        term = 40'(r_prod >>> 27);
        sum  = r_pneg ? r_acc - term : r_acc + term;
        if (sum > 40'sh007FFFFFFF) sat = 32'sh7FFFFFFF;
        else if (sum < -40'sh0080000000) sat = 32'sh80000000;
        else sat = 32'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_mvalid <= 1'b0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
            for (int k = 0; k < bqc_pkg::CoeffsPerSect; k++) begin
                r_cur[k]  <= '0;
                r_old[k]  <= '0;
                r_pend[k] <= '0;
            end
            for (int c = 0; c < bqc_pkg::MaxChannels; c++) begin
                r_x1[c] <= '0;
                r_x2[c] <= '0;
                r_y1[c] <= '0;
                r_y2[c] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_bank.wr_en && i_bank.sec == i_my_sec)
                r_pend[i_bank.cidx] <= i_bank.value;
            if (i_bank.commit)
                for (int k = 0; k < bqc_pkg::CoeffsPerSect; k++) r_cur[k] <= r_pend[k];
            if (i_bank.settle)
                for (int k = 0; k < bqc_pkg::CoeffsPerSect; k++) r_old[k] <= r_cur[k];
            // stage 1: select coefficient and operand
            r_mvalid <= r_busy;
            if (r_busy) begin
                r_coef <= n_coef;
                r_sig  <= n_sig;
                r_neg  <= (r_step >= 3'd3);
                r_last <= (r_step == 3'd4);
                if (r_step == 3'd4) r_busy <= 1'b0;
                r_step <= r_step + 3'd1;
            end
            // stage 2: multiply
            r_pvalid <= r_mvalid;
            if (r_mvalid) begin
                r_prod  <= 64'(r_coef) * 64'(r_sig);
                r_pneg  <= r_neg;
                r_plast <= r_last;
            end
            // stage 3: accumulate
            if (r_pvalid) begin
                r_acc <= sum;
                if (r_plast) begin
                    r_y          <= sat;
                    r_done       <= 1'b1;
                    r_x2[r_ch]   <= r_x1[r_ch];
                    r_x1[r_ch]   <= r_x;
                    r_y2[r_ch]   <= r_y1[r_ch];
                    r_y1[r_ch]   <= sat;
                end
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_acc  <= '0;
                r_x    <= i_x;
                r_ch   <= i_ch;
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;
endmodule

// ===== src/biquad_cascade_smooth_coeff_top.sv =====
// Top level of the biquad cascade: request handling, frame/ramp control and the cell chain.
// Depends on bqc_pkg, bqc_if and bqc_cell.
//
// A sample request passes through the active sections one after another; each cell
// runs its five products through one multiplier and its select, multiply and accumulate
// stages. A coefficient write or commit holds off the next request until it has been
// registered to the cell banks. One request is in work at a time. Signals are Q8.23,
// coefficients Q4.27; the result saturates to int16.
module biquad_cascade_smooth_coeff_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bqc_if.sink                            i_req,
    bqc_if.source                          o_res,
    input  logic                           i_cfg_we,
    input  logic [bqc_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [bqc_pkg::CfgDataW-1:0]   i_cfg_data
);
    // request payload: {opcode, sample_in, channel, section_index, coeff_index, coeff_value}
    // result payload: {sample_out, out_channel}
    localparam int NS = bqc_pkg::MaxSections;

    logic               r_smooth;
    logic [4:0]         r_nsec;
    logic [1:0]         r_nch;
    logic [3:0]         r_l2;
    logic [bqc_pkg::PosW-1:0] r_pos;
    logic               r_ramping;
    logic               r_waiting;
    bqc_pkg::t_state    r_state, n_state;
    logic [bqc_pkg::CntW-1:0] r_k;
    logic               r_ch;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [15:0] r_out;
    logic               r_och;
    logic               r_ovalid;
    bqc_pkg::t_bank_ctl r_bank;

    logic [1:0]          op;
    logic signed [15:0]  smp;
    logic                ch;
    logic                accept;
    logic [1:0]          eff_ch;
    logic [3:0]          eff_l2;
    logic [4:0]          eff_sec;
    bqc_pkg::t_coef_ctx  ctx;
    logic [NS-1:0]       start;
    logic [NS-1:0]       done;
    logic signed [31:0]  cell_y [NS];
    logic signed [31:0]  x_conv;
    logic signed [15:0]  y_conv;
    logic                last_ch;
    logic [10:0]         pos_inc;
    logic                wrap;

    assign op  = i_req.data[57:56];
    assign smp = i_req.data[55:40];
    assign ch  = i_req.data[39];
    assign accept = i_req.valid && i_req.ready;

    assign eff_ch  = (r_nch < 2'd1) ? 2'd1 : ((r_nch > 2'd2) ? 2'd2 : r_nch);
    assign eff_l2  = (r_l2 < 4'd2) ? 4'd2 : ((r_l2 > 4'd10) ? 4'd10 : r_l2);
    assign eff_sec = (r_nsec > 5'd16) ? 5'd16 : r_nsec;
    assign ctx = '{ramping: r_ramping, smooth: r_smooth, log2: eff_l2, pos: r_pos};

    // x = round(s * 2^23 / 32767): |s| * 2^23 is divided by 32767 with an estimate, one
    // correction and a rounding compare on the remainder, then the sign is restored.
    always_comb begin
        logic signed [40:0] num;
        logic        [40:0] m;
        logic        [40:0] q;
        logic        [40:0] r;
        num = 41'(smp) * 41'sd8388608;
        m   = num[40] ? 41'(-num) : num;
        // m <= 2^38; divide by 32767 via q = m*(2^15+1)>>30 estimate then fix
        q   = 41'((56'(m) * 56'd32769) >> 30);
        r   = m - q * 41'd32767;
        if (r >= 41'd32767) begin
            q = q + 41'd1;
            r = r - 41'd32767;
        end
        if (r >= 41'd16384) q = q + 41'd1;
        x_conv = num[40] ? -32'(q) : 32'(q);
    end

    // out = round(y * 32767 / 2^23), saturated
    always_comb begin
        logic signed [47:0] num;
        logic        [47:0] m;
        logic        [47:0] q;
        logic signed [48:0] v;
        num = 48'(r_y) * 48'sd32767;
        m   = num[47] ? 48'(-num) : num;
        q   = (m + 48'd4194304) >> 23;
        v   = num[47] ? -49'(q) : 49'(q);
        if (v > 49'sd32767) y_conv = 16'sh7FFF;
        else if (v < -49'sd32768) y_conv = 16'sh8000;
        else y_conv = 16'(v);
    end

    assign last_ch = (2'(r_ch) == eff_ch - 2'd1);
    assign pos_inc = 11'(r_pos) + 11'd1;
    assign wrap    = pos_inc >= (11'd1 << eff_l2);

    // cell 0 starts at the accepting edge, so it takes the sample straight from the request
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_cell
            bqc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_bank   (r_bank),
                .i_my_sec (bqc_pkg::SecW'(g)),
                .i_start  (start[g]),
                .i_x      (g == 0 ? x_conv : cell_y[(g == 0) ? 0 : g-1]),
                .i_ch     (g == 0 ? ch : r_ch),
                .i_ctx    (ctx),
                .o_done   (done[g]),
                .o_y      (cell_y[g])
            );
        end
    endgenerate

    // cell k starts when its predecessor finishes, cell 0 on entry to RUN
    always_comb begin
        start = '0;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) start[k] = (r_state == bqc_pkg::ST_IDLE) && accept &&
                                   op == bqc_pkg::OP_SAMPLE && eff_sec != 5'd0 &&
                                   2'(ch) < eff_ch;
            else start[k] = done[k-1] && (5'(k) < eff_sec);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bqc_pkg::ST_IDLE:
                if (accept && op == bqc_pkg::OP_SAMPLE && 2'(ch) < eff_ch)
                    n_state = (eff_sec == 5'd0) ? bqc_pkg::ST_FINISH : bqc_pkg::ST_RUN;
            bqc_pkg::ST_RUN:
                if (done[r_k[bqc_pkg::SecW-1:0]] && r_k == eff_sec - 5'd1)
                    n_state = bqc_pkg::ST_FINISH;
            bqc_pkg::ST_FINISH: n_state = bqc_pkg::ST_OUT;
            bqc_pkg::ST_OUT:    n_state = bqc_pkg::ST_IDLE;
            default:            n_state = bqc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == bqc_pkg::ST_IDLE) && !r_ovalid && !r_bank.wr_en &&
                      !r_bank.commit;
        o_res.valid = r_ovalid;
        o_res.data  = {r_out, r_och};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bqc_pkg::ST_IDLE;
            r_smooth  <= 1'b1;
            r_nsec    <= '0;
            r_nch     <= 2'd1;
            r_l2      <= 4'd6;
            r_pos     <= '0;
            r_ramping <= 1'b0;
            r_waiting <= 1'b0;
            r_ovalid  <= 1'b0;
            r_bank    <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            r_bank.wr_en  <= 1'b0;
            r_bank.commit <= 1'b0;
            r_bank.settle <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bqc_pkg::CFG_SMOOTH:   r_smooth <= i_cfg_data[0];
                    bqc_pkg::CFG_SECTIONS: r_nsec   <= i_cfg_data[4:0];
                    bqc_pkg::CFG_CHANNELS: r_nch    <= i_cfg_data[1:0];
                    bqc_pkg::CFG_BLKLOG2:  r_l2     <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            if (accept) begin
                if (op == bqc_pkg::OP_WRITE) begin
                    r_bank.wr_en <= (i_req.data[34:32] < 3'd5);
                    r_bank.sec   <= i_req.data[38:35];
                    r_bank.cidx  <= i_req.data[34:32];
                    r_bank.value <= i_req.data[31:0];
                end else if (op == bqc_pkg::OP_COMMIT) begin
                    r_bank.commit <= 1'b1;
                    r_waiting     <= 1'b1;
                end else if (op == bqc_pkg::OP_SAMPLE) begin
                    r_x  <= x_conv;
                    r_y  <= x_conv;
                    r_ch <= ch;
                    r_k  <= '0;
                end
            end
            if (r_state == bqc_pkg::ST_RUN && done[r_k[bqc_pkg::SecW-1:0]]) begin
                r_y <= cell_y[r_k[bqc_pkg::SecW-1:0]];
                r_k <= r_k + 5'd1;
            end
            if (r_state == bqc_pkg::ST_FINISH) begin
                r_out    <= y_conv;
                r_och    <= r_ch;
                r_ovalid <= 1'b1;
                if (last_ch) begin
                    if (wrap) begin
                        r_pos <= '0;
                        if (r_waiting) begin
                            r_ramping     <= r_smooth;
                            r_bank.settle <= r_ramping || !r_smooth;
                            r_waiting     <= 1'b0;
                        end else begin
                            r_ramping     <= 1'b0;
                            r_bank.settle <= r_ramping;
                        end
                    end else begin
                        r_pos <= pos_inc[bqc_pkg::PosW-1:0];
                    end
                end
            end
        end
    end
endmodule
